// ===== hdl/sv32ptw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv32ptw_pkg
// Shared types, register indexes and Sv32 PTE helpers for the page table
// walker.
// ----------------------------------------------------------------------------
package sv32ptw_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned PpnW    = 20;
  localparam int unsigned FlagW   = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = PpnW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROOT_PPN   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TLB_ENABLE = 1'b1;

  // One cycle of requester, TLB and memory inputs
  typedef struct packed {
    logic             req;
    logic [AddrW-1:0] virt_addr;
    logic             tlb_hit;
    logic             tlb_absent;
    logic             tlb_superpage;
    logic [PpnW-1:0]  tlb_ppn;
    logic [FlagW-1:0] tlb_flags;
    logic             mem_ack;
    logic [AddrW-1:0] mem_data;
  } item_t;

  // One cycle of walker outputs
  typedef struct packed {
    logic             done_res;
    logic [AddrW-1:0] phys_addr;
    logic [FlagW-1:0] access_flags;
    logic             tlb_lookup;
    logic             tlb_write;
    logic [PpnW-1:0]  tlb_vpn;
    logic [PpnW-1:0]  tlb_new_ppn;
    logic             tlb_new_super;
    logic [FlagW-1:0] tlb_new_flags;
    logic             mem_read;
    logic [AddrW-1:0] mem_addr;
  } res_t;

  function automatic logic [PpnW-1:0] pte_ppn(input logic [AddrW-1:0] p);
    return p[29:10];
  endfunction

  function automatic logic [AddrW-1:0] pte_frame(input logic [AddrW-1:0] p);
    return {p[29:10], 12'h000};
  endfunction

  // R,W,X,U,D,A in bits 0 to 5
  function automatic logic [FlagW-1:0] pte_flags(input logic [AddrW-1:0] p);
    return {p[6], p[7], p[4], p[3], p[2], p[1]};
  endfunction

  function automatic logic pte_invalid(input logic [AddrW-1:0] p);
    return !p[0] || (!p[1] && p[2]);
  endfunction

  function automatic logic pte_leaf(input logic [AddrW-1:0] p);
    return p[1] || p[3];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sv32ptw_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv32ptw_core
// Walk state machine: Moore outputs from the walk registers, advanced once
// per transferred input item.
// ----------------------------------------------------------------------------
module sv32ptw_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire sv32ptw_pkg::item_t        item_i,
  input  wire logic [sv32ptw_pkg::PpnW-1:0] root_ppn_i,
  input  wire logic                      tlb_enable_i,
  output sv32ptw_pkg::res_t              res_o
);
  import sv32ptw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_LOOKUP    = 4'd1,
    ST_HIT       = 4'd2,
    ST_HIT_SUPER = 4'd3,
    ST_FETCH1    = 4'd4,
    ST_CHECK1    = 4'd5,
    ST_FETCH2    = 4'd6,
    ST_CHECK2    = 4'd7,
    ST_OK_SUPER  = 4'd8,
    ST_OK_PAGE   = 4'd9,
    ST_FAULT     = 4'd10
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] pte_q, pte_d;
  logic [AddrW-1:0] vaddr_q, vaddr_d;
  logic [AddrW-1:0] frame;

  assign frame = pte_frame(pte_q);

  // Outputs
  always_comb begin
    res_o               = '0;
    res_o.phys_addr     = frame | {20'h0, vaddr_q[11:0]};
    res_o.access_flags  = pte_flags(pte_q);
    res_o.mem_addr      = frame | {20'h0, vaddr_q[31:22], 2'b00};
    case (state_q)
      ST_LOOKUP: begin
        res_o.tlb_lookup = 1'b1;
        res_o.tlb_vpn    = vaddr_q[31:12];
      end
      ST_HIT: begin
        res_o.done_res = 1'b1;
      end
      ST_HIT_SUPER: begin
        res_o.done_res  = 1'b1;
        res_o.phys_addr = frame | {10'h0, vaddr_q[21:0]};
      end
      ST_FETCH1: begin
        res_o.mem_read = 1'b1;
      end
      ST_FETCH2: begin
        res_o.mem_read = 1'b1;
        res_o.mem_addr = frame | {20'h0, vaddr_q[21:12], 2'b00};
      end
      ST_FAULT: begin
        res_o.done_res     = 1'b1;
        res_o.access_flags = '0;
      end
      ST_OK_SUPER, ST_OK_PAGE: begin
        res_o.done_res = 1'b1;
        if (state_q == ST_OK_SUPER) begin
          res_o.phys_addr = frame | {10'h0, vaddr_q[21:0]};
        end
        if (tlb_enable_i) begin
          res_o.tlb_write     = 1'b1;
          res_o.tlb_vpn       = vaddr_q[31:12];
          res_o.tlb_new_ppn   = pte_ppn(pte_q);
          res_o.tlb_new_super = (state_q == ST_OK_SUPER);
          res_o.tlb_new_flags = pte_flags(pte_q);
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    pte_d   = pte_q;
    vaddr_d = vaddr_q;
    case (state_q)
      ST_IDLE: begin
        vaddr_d = item_i.virt_addr;
        pte_d   = {2'b00, root_ppn_i, 10'h000};
        if (item_i.req) begin
          state_d = tlb_enable_i ? ST_LOOKUP : ST_FETCH1;
        end
      end
      ST_LOOKUP: begin
        if (item_i.tlb_absent) begin
          state_d = ST_FETCH1;
        end else if (item_i.tlb_hit) begin
          state_d = item_i.tlb_superpage ? ST_HIT_SUPER : ST_HIT;
          // keep V, W, X, U and G, OR in flags and load ppn from the TLB entry
          pte_d = (pte_q & 32'h0000_003D)
                | {2'b00, item_i.tlb_ppn, 2'b00,
                   item_i.tlb_flags[4], item_i.tlb_flags[5], 1'b0,
                   item_i.tlb_flags[3], item_i.tlb_flags[2],
                   item_i.tlb_flags[1], item_i.tlb_flags[0], 1'b0};
        end
      end
      ST_FETCH1: begin
        if (item_i.mem_ack) begin
          pte_d   = item_i.mem_data;
          state_d = ST_CHECK1;
        end
      end
      ST_CHECK1: begin
        if (pte_invalid(pte_q)) begin
          state_d = ST_FAULT;
        end else if (pte_leaf(pte_q)) begin
          // leaf at level 1 is a superpage; a misaligned one faults
          state_d = (pte_q[19:10] != 10'h000) ? ST_FAULT : ST_OK_SUPER;
        end else begin
          state_d = ST_FETCH2;
        end
      end
      ST_FETCH2: begin
        if (item_i.mem_ack) begin
          pte_d   = item_i.mem_data;
          state_d = ST_CHECK2;
        end
      end
      ST_CHECK2: begin
        state_d = (pte_leaf(pte_q) && !pte_invalid(pte_q)) ? ST_OK_PAGE : ST_FAULT;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pte_q   <= '0;
      vaddr_q <= '0;
    end else if (adv_i) begin
      state_q <= state_d;
      pte_q   <= pte_d;
      vaddr_q <= vaddr_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sv32_page_table_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv32_page_table_walker
// Two-level Sv32 page table walker with optional TLB lookup, stepped once per
// transferred input item.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  --------  -------------------------  --------------------------------------
//  input     in_valid_i / in_stall_o    req, virt_addr, tlb_*, mem_ack/data
//  output    out_valid_o / out_stall_i  done_res, phys_addr, ..., mem_addr
//  config    cfg_we_i                   cfg_index_i, cfg_data_i
//
//  Each input transfer advances the walk by at most one state and loads
//  one result into the output register, offered as one output transfer.
//  Throughput is one item per cycle while the sink does not stall.
//  in_stall_o rises only while a result sits in the output register and the
//  sink stalls, so a new item is taken in the same cycle the old one drains.
//  Reset clears the walk state, the PTE and address registers, and the
//  output valid; root_ppn resets to 0 and tlb_enable to 1.
// ----------------------------------------------------------------------------
module sv32_page_table_walker (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // configuration
  input  wire logic                                cfg_we_i,
  input  wire logic [sv32ptw_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [sv32ptw_pkg::CfgW-1:0]        cfg_data_i,
  // input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                req_i,
  input  wire logic [sv32ptw_pkg::AddrW-1:0]       virt_addr_i,
  input  wire logic                                tlb_hit_i,
  input  wire logic                                tlb_absent_i,
  input  wire logic                                tlb_megapage_i,
  input  wire logic [sv32ptw_pkg::PpnW-1:0]        tlb_ppn_i,
  input  wire logic [sv32ptw_pkg::FlagW-1:0]       tlb_flags_i,
  input  wire logic                                mem_ack_i,
  input  wire logic [sv32ptw_pkg::AddrW-1:0]       mem_data_i,
  // output channel
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     done_res_o,
  output logic [sv32ptw_pkg::AddrW-1:0]            phys_addr_o,
  output logic [sv32ptw_pkg::FlagW-1:0]            access_flags_o,
  output logic                                     tlb_lookup_o,
  output logic                                     tlb_write_o,
  output logic [sv32ptw_pkg::PpnW-1:0]             tlb_vpn_o,
  output logic [sv32ptw_pkg::PpnW-1:0]             tlb_new_ppn_o,
  output logic                                     tlb_new_super_o,
  output logic [sv32ptw_pkg::FlagW-1:0]            tlb_new_flags_o,
  output logic                                     mem_read_o,
  output logic [sv32ptw_pkg::AddrW-1:0]            mem_addr_o
);
  import sv32ptw_pkg::*;

  logic [PpnW-1:0] root_ppn_q;
  logic            tlb_enable_q;
  logic            out_valid_q;
  res_t            res_q;
  res_t            res_d;
  item_t           item;
  logic            in_xfer;
  logic            out_xfer;

  // Configuration registers; a write takes effect from the next input
  // transfer on, even in the middle of a walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ppn_q   <= '0;
      tlb_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROOT_PPN:   root_ppn_q   <= cfg_data_i;
        CFG_TLB_ENABLE: tlb_enable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: hold the input only while a result waits on a stalled sink.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;

  assign item = '{
    req:           req_i,
    virt_addr:     virt_addr_i,
    tlb_hit:       tlb_hit_i,
    tlb_absent:    tlb_absent_i,
    tlb_superpage: tlb_megapage_i,
    tlb_ppn:       tlb_ppn_i,
    tlb_flags:     tlb_flags_i,
    mem_ack:       mem_ack_i,
    mem_data:      mem_data_i
  };

  // Walk registers advance on each input transfer; res_d is the Moore output
  // of the state before that step.
  sv32ptw_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (in_xfer),
    .item_i       (item),
    .root_ppn_i   (root_ppn_q),
    .tlb_enable_i (tlb_enable_q),
    .res_o        (res_d)
  );

  // Output register: load on input transfer, drop valid once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign done_res_o      = res_q.done_res;
  assign phys_addr_o     = res_q.phys_addr;
  assign access_flags_o  = res_q.access_flags;
  assign tlb_lookup_o    = res_q.tlb_lookup;
  assign tlb_write_o     = res_q.tlb_write;
  assign tlb_vpn_o       = res_q.tlb_vpn;
  assign tlb_new_ppn_o   = res_q.tlb_new_ppn;
  assign tlb_new_super_o = res_q.tlb_new_super;
  assign tlb_new_flags_o = res_q.tlb_new_flags;
  assign mem_read_o      = res_q.mem_read;
  assign mem_addr_o      = res_q.mem_addr;

endmodule
`default_nettype wire

// ===== hdl/sv32ptw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sv32ptw_checker
// Port-level checks for the page table walker, bound to the top level.
// ----------------------------------------------------------------------------
module sv32ptw_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       done_res_o,
  input wire logic [5:0] access_flags_o,
  input wire logic       tlb_lookup_o,
  input wire logic       tlb_write_o,
  input wire logic [5:0] tlb_new_flags_o,
  input wire logic       mem_read_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input is held back only by a stalled pending result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending stalled result");

  // Every input transfer yields a result next cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("input transfer produced no result");

  // Acknowledge never coincides with a lookup or a PTE read.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !tlb_lookup_o && !mem_read_o)
    else $error("acknowledge overlaps lookup or memory read");

  // A TLB write comes with an acknowledge carrying the same flags.
  a_tlb_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tlb_write_o |-> done_res_o && (access_flags_o == tlb_new_flags_o))
    else $error("TLB write without matching acknowledge");

endmodule

bind sv32_page_table_walker sv32ptw_checker u_sv32ptw_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .done_res_o      (done_res_o),
  .access_flags_o  (access_flags_o),
  .tlb_lookup_o    (tlb_lookup_o),
  .tlb_write_o     (tlb_write_o),
  .tlb_new_flags_o (tlb_new_flags_o),
  .mem_read_o      (mem_read_o)
);
`default_nettype wire

// ===== verif/walk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walk_checker
// Watches the walker's input, output and register ports. Keeps its own copy
// of the walk state and registers, predicts the outputs of every input
// transfer and compares each output transfer field by field in order.
// ----------------------------------------------------------------------------
module walk_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sv32ptw_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sv32ptw_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_i,
  input  sv32ptw_pkg::item_t                    in_item_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_stall_i,
  input  sv32ptw_pkg::res_t                     out_res_i,
  output int unsigned                           pending_o,
  output int unsigned                           errors_o
);
  import sv32ptw_pkg::*;

  typedef enum logic [3:0] {
    WS_IDLE      = 4'd0,
    WS_LOOKUP    = 4'd1,
    WS_HIT       = 4'd2,
    WS_HIT_SUPER = 4'd3,
    WS_FETCH1    = 4'd4,
    WS_CHECK1    = 4'd5,
    WS_FETCH2    = 4'd6,
    WS_CHECK2    = 4'd7,
    WS_OK_SUPER  = 4'd8,
    WS_OK_PAGE   = 4'd9,
    WS_FAULT     = 4'd10
  } walk_state_e;

  localparam int unsigned MaxReports = 40;

  walk_state_e     walk_st;
  logic [31:0]     pte_q;
  logic [31:0]     va_q;
  logic [PpnW-1:0] root_c;
  logic            tlb_en_c;
  res_t            walker_out_q[$];
  int unsigned     err_cnt;

  // Moore outputs come from the state before the edge; then advance it.
  function automatic res_t step_walker(input item_t it);
    res_t        r;
    logic [31:0] frame;
    logic        bad;
    logic        leaf;
    r     = '0;
    frame = {pte_q[29:10], 12'h000};
    bad   = !pte_q[0] || (pte_q[2] && !pte_q[1]);
    leaf  = pte_q[1] || pte_q[3];
    r.phys_addr    = frame | {20'h0, va_q[11:0]};
    r.access_flags = {pte_q[6], pte_q[7], pte_q[4], pte_q[3], pte_q[2], pte_q[1]};
    r.mem_addr     = frame | {20'h0, va_q[31:22], 2'b00};
    case (walk_st)
      WS_LOOKUP: begin
        r.tlb_lookup = 1'b1;
        r.tlb_vpn    = va_q[31:12];
      end
      WS_HIT: r.done_res = 1'b1;
      WS_HIT_SUPER: begin
        r.done_res  = 1'b1;
        r.phys_addr = frame | {10'h0, va_q[21:0]};
      end
      WS_FETCH1: r.mem_read = 1'b1;
      WS_FETCH2: begin
        r.mem_read = 1'b1;
        r.mem_addr = frame | {20'h0, va_q[21:12], 2'b00};
      end
      WS_FAULT: begin
        r.done_res     = 1'b1;
        r.access_flags = '0;
      end
      WS_OK_SUPER, WS_OK_PAGE: begin
        r.done_res = 1'b1;
        if (walk_st == WS_OK_SUPER) r.phys_addr = frame | {10'h0, va_q[21:0]};
        if (tlb_en_c) begin
          r.tlb_write     = 1'b1;
          r.tlb_vpn       = va_q[31:12];
          r.tlb_new_ppn   = pte_q[29:10];
          r.tlb_new_super = (walk_st == WS_OK_SUPER);
          r.tlb_new_flags = r.access_flags;
        end
      end
      default: ;
    endcase

    case (walk_st)
      WS_IDLE: begin
        va_q  = it.virt_addr;
        pte_q = {2'b00, root_c, 10'h000};
        if (it.req) walk_st = tlb_en_c ? WS_LOOKUP : WS_FETCH1;
      end
      WS_LOOKUP: begin
        if (it.tlb_absent) begin
          walk_st = WS_FETCH1;
        end else if (it.tlb_hit) begin
          walk_st = it.tlb_superpage ? WS_HIT_SUPER : WS_HIT;
          // keep V, W, X, U and G, OR in flags and take ppn from the TLB entry
          pte_q = (pte_q & 32'h0000_003D)
                | {2'b00, it.tlb_ppn, 2'b00, it.tlb_flags[4], it.tlb_flags[5], 1'b0,
                   it.tlb_flags[3], it.tlb_flags[2], it.tlb_flags[1], it.tlb_flags[0], 1'b0};
        end
      end
      WS_FETCH1, WS_FETCH2: begin
        if (it.mem_ack) begin
          pte_q   = it.mem_data;
          walk_st = (walk_st == WS_FETCH1) ? WS_CHECK1 : WS_CHECK2;
        end
      end
      WS_CHECK1: begin
        if (bad) walk_st = WS_FAULT;
        else if (leaf) walk_st = (pte_q[19:10] != 10'h0) ? WS_FAULT : WS_OK_SUPER;
        else walk_st = WS_FETCH2;
      end
      WS_CHECK2: walk_st = (leaf && !bad) ? WS_OK_PAGE : WS_FAULT;
      default: walk_st = WS_IDLE;
    endcase
    return r;
  endfunction

  task automatic note_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MaxReports)
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      walk_st  = WS_IDLE;
      pte_q    = '0;
      va_q     = '0;
      root_c   = '0;
      tlb_en_c = 1'b1;
      err_cnt  = 0;
      walker_out_q.delete();
    end else begin
      // drain first: an output leaving at this edge belongs to an older transfer
      if (out_valid_i && !out_stall_i) begin
        if (walker_out_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("%0t ns: output transfer with none expected, got %h", $time, out_res_i);
        end else begin
          want = walker_out_q.pop_front();
          note_field("done_res",      32'(want.done_res),      32'(out_res_i.done_res));
          note_field("phys_addr",     want.phys_addr,          out_res_i.phys_addr);
          note_field("access_flags",  32'(want.access_flags),  32'(out_res_i.access_flags));
          note_field("tlb_lookup",    32'(want.tlb_lookup),    32'(out_res_i.tlb_lookup));
          note_field("tlb_write",     32'(want.tlb_write),     32'(out_res_i.tlb_write));
          note_field("tlb_vpn",       32'(want.tlb_vpn),       32'(out_res_i.tlb_vpn));
          note_field("tlb_new_ppn",   32'(want.tlb_new_ppn),   32'(out_res_i.tlb_new_ppn));
          note_field("tlb_new_super", 32'(want.tlb_new_super), 32'(out_res_i.tlb_new_super));
          note_field("tlb_new_flags", 32'(want.tlb_new_flags), 32'(out_res_i.tlb_new_flags));
          note_field("mem_read",      32'(want.mem_read),      32'(out_res_i.mem_read));
          note_field("mem_addr",      want.mem_addr,           out_res_i.mem_addr);
        end
      end
      if (in_valid_i && !in_stall_i) walker_out_q.push_back(step_walker(in_item_i));
      // a register write shows up from the next step on
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ROOT_PPN:   root_c   = cfg_data_i[PpnW-1:0];
          CFG_TLB_ENABLE: tlb_en_c = cfg_data_i[0];
          default: ;
        endcase
      end
    end
    pending_o <= walker_out_q.size();
    errors_o  <= err_cnt;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the Sv32 page table walker one cycle item at a time: a directed
// walk through hits, misses, both fetch levels and faults, then random
// phases under several register settings with random gaps and stalls.
// The walk_checker instance predicts and compares every output transfer.
// ----------------------------------------------------------------------------
module tb;
  import sv32ptw_pkg::*;

  // Sv32 PTE bits used to shape memory answers
  localparam logic [31:0] PTE_V = 32'h0000_0001;
  localparam logic [31:0] PTE_R = 32'h0000_0002;
  localparam logic [31:0] PTE_W = 32'h0000_0004;
  localparam logic [31:0] PTE_X = 32'h0000_0008;
  localparam logic [31:0] PTE_A = 32'h0000_0040;
  localparam logic [31:0] PTE_D = 32'h0000_0080;
  // ppn[0] field; must be zero for a usable superpage
  localparam logic [31:0] PTE_PPN0 = 32'h000F_FC00;

  localparam int unsigned PhaseItems = 270;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  item_t              stim;
  logic               out_valid_o;
  logic               out_stall_i;

  logic               done_res;
  logic [AddrW-1:0]   phys_addr;
  logic [FlagW-1:0]   access_flags;
  logic               tlb_lookup;
  logic               tlb_write;
  logic [PpnW-1:0]    tlb_vpn;
  logic [PpnW-1:0]    tlb_new_ppn;
  logic               tlb_new_super;
  logic [FlagW-1:0]   tlb_new_flags;
  logic               mem_read;
  logic [AddrW-1:0]   mem_addr;
  res_t               walker_out;

  int unsigned        pending;
  int unsigned        errors;
  int unsigned        sent_count;
  int unsigned        settings_count;
  int unsigned        gap_pct;
  int unsigned        stall_pct;
  int unsigned        stall_left;

  always #5 clk_i = ~clk_i;

  sv32_page_table_walker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_i           (stim.req),
    .virt_addr_i     (stim.virt_addr),
    .tlb_hit_i       (stim.tlb_hit),
    .tlb_absent_i    (stim.tlb_absent),
    .tlb_megapage_i  (stim.tlb_superpage),
    .tlb_ppn_i       (stim.tlb_ppn),
    .tlb_flags_i     (stim.tlb_flags),
    .mem_ack_i       (stim.mem_ack),
    .mem_data_i      (stim.mem_data),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .done_res_o      (done_res),
    .phys_addr_o     (phys_addr),
    .access_flags_o  (access_flags),
    .tlb_lookup_o    (tlb_lookup),
    .tlb_write_o     (tlb_write),
    .tlb_vpn_o       (tlb_vpn),
    .tlb_new_ppn_o   (tlb_new_ppn),
    .tlb_new_super_o (tlb_new_super),
    .tlb_new_flags_o (tlb_new_flags),
    .mem_read_o      (mem_read),
    .mem_addr_o      (mem_addr)
  );

  assign walker_out = '{done_res: done_res, phys_addr: phys_addr,
                        access_flags: access_flags, tlb_lookup: tlb_lookup,
                        tlb_write: tlb_write, tlb_vpn: tlb_vpn,
                        tlb_new_ppn: tlb_new_ppn, tlb_new_super: tlb_new_super,
                        tlb_new_flags: tlb_new_flags, mem_read: mem_read,
                        mem_addr: mem_addr};

  walk_checker u_walk_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (stim),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_i   (walker_out),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Sink side: stall in bursts, mostly short, now and then a
  // long one. A stall_pct of zero gives full-rate stretches.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                 : $urandom_range(0, 2);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Build one cycle of requester, TLB and memory inputs.
  function automatic item_t walk_cycle(input logic req, input logic [31:0] va,
                                       input logic hit, input logic miss,
                                       input logic sup, input logic [19:0] ppn,
                                       input logic [5:0] flags, input logic ack,
                                       input logic [31:0] data);
    item_t it;
    it.req           = req;
    it.virt_addr     = va;
    it.tlb_hit       = hit;
    it.tlb_absent    = miss;
    it.tlb_superpage = sup;
    it.tlb_ppn       = ppn;
    it.tlb_flags     = flags;
    it.mem_ack       = ack;
    it.mem_data      = data;
    return it;
  endfunction

  // Transfer one cycle item, optionally after a gap with valid low. Called
  // right after a rising edge; returns at the edge where the transfer happens.
  task automatic send_cycle(input item_t it);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    stim       <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  // Drop valid and hold until every predicted output has been transferred.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back; the sender is idle here.
  task automatic load_settings(input logic [PpnW-1:0] root, input logic en);
    cfg_index_i <= CFG_ROOT_PPN;
    cfg_data_i  <= root;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_index_i <= CFG_TLB_ENABLE;
    cfg_data_i  <= {{(CfgW-1){1'b0}}, en};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_count++;
  endtask

  // Random cycles biased so that walks run deep: requests are frequent, the
  // TLB mostly answers, memory mostly acknowledges, and PTE words are shaped
  // into pointers, superpage leaves, plain leaves and broken entries.
  task automatic run_random_phase(input int unsigned count);
    item_t       it;
    logic [31:0] pte;
    int unsigned pick;
    repeat (count) begin
      it.req       = ($urandom_range(0, 4) != 0);
      it.virt_addr = $urandom();
      pick = $urandom_range(0, 19);
      if (pick == 0) it.virt_addr = '0;
      else if (pick == 1) it.virt_addr = '1;
      // miss only, hit only, both at once (miss wins) or no answer yet
      pick = $urandom_range(0, 9);
      it.tlb_absent    = (pick < 4) || (pick == 8);
      it.tlb_hit       = (pick >= 4) && (pick <= 8);
      it.tlb_superpage = 1'($urandom_range(0, 1));
      it.tlb_ppn       = 20'($urandom_range(0, 20'hFFFFF));
      it.tlb_flags     = 6'($urandom_range(0, 63));
      it.mem_ack       = ($urandom_range(0, 3) != 0);
      pte  = $urandom();
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: pte = (pte & ~(PTE_R | PTE_W | PTE_X)) | PTE_V;
        3, 4:    pte = (pte & ~PTE_PPN0) | PTE_V | PTE_R;
        5:       pte = (pte & ~(PTE_R | PTE_W)) | PTE_V | PTE_X;
        6:       pte = pte & ~PTE_V;
        7:       pte = (pte & ~PTE_R) | PTE_V | PTE_W;
        default: ;
      endcase
      it.mem_data = pte;
      send_cycle(it);
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= CFG_ROOT_PPN;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    stim           <= '0;
    out_stall_i    <= 1'b0;
    stall_left      = 0;
    sent_count      = 0;
    settings_count  = 1;
    gap_pct         = 20;
    stall_pct       = 20;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed walks under reset settings (root 0, TLB on).
    // superpage TLB hit with all-ones fields
    send_cycle(walk_cycle(1, 32'hFFFF_FFFF, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 1, 0, 1, 20'hFFFFF, 6'h3F, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    // lookup left waiting for an answer, then a plain page hit
    send_cycle(walk_cycle(1, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 1, 0, 0, 20'h12345, 6'h2A, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    // hit and miss together take the miss; two-level walk with acknowledge
    // held back at both levels, ending in a TLB write
    send_cycle(walk_cycle(1, 32'h1234_5678, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 1, 1, 1, 20'hFFFFF, 6'h3F, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'hFFFF_FFFF));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 1,
                          {2'b11, 20'hABCDE, 10'h000} | PTE_V));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 1, 32'hFFFF_FFFF));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    // level-1 superpage leaf with ppn[0] zero succeeds
    send_cycle(walk_cycle(1, 32'hFFC0_0ABC, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 1, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 1,
                          32'h3FF0_0000 | PTE_V | PTE_R | PTE_X | PTE_A | PTE_D));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    // misaligned superpage (ppn[0] nonzero) faults
    send_cycle(walk_cycle(1, 32'h8040_1FFF, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 1, 0, 20'h0, 6'h00, 0, 32'h0));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 1,
                          32'h0000_0400 | PTE_V | PTE_X));
    send_cycle(walk_cycle(0, 32'h0, 0, 0, 0, 20'h0, 6'h00, 0, 32'h0));

    // Random phases. Each one starts only after the walker has drained, so
    // registers change with the interface idle but often mid-walk.
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: begin load_settings(20'hFFFFF, 1'b0); gap_pct = 25; stall_pct = 25; end
        1: begin
          load_settings(20'($urandom_range(0, 20'hFFFFF)), 1'b1);
          gap_pct = 0; stall_pct = 0;
        end
        2: begin load_settings(20'h00000, 1'b0); gap_pct = 40; stall_pct = 10; end
        3: begin
          load_settings(20'($urandom_range(0, 20'hFFFFF)), 1'b1);
          gap_pct = 10; stall_pct = 50;
        end
        4: begin load_settings(20'hFFFFF, 1'b1); gap_pct = 30; stall_pct = 30; end
        default: begin
          load_settings(20'($urandom_range(0, 20'hFFFFF)), 1'($urandom_range(0, 1)));
          gap_pct   = 5;
          stall_pct = 5;
        end
      endcase
      run_random_phase(PhaseItems);
    end

    // Drain, then keep watching for stray output before the summary.
    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d input transfers under %0d register settings,", sent_count,
             settings_count);
    $display("walks through TLB hits, misses, both fetch levels, faults and TLB writes.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run with longest gaps and stalls.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sv32_page_table_walker.f =====
hdl/sv32ptw_pkg.sv
hdl/sv32ptw_core.sv
hdl/sv32_page_table_walker.sv
hdl/sv32ptw_checker.sv
verif/walk_checker.sv
verif/tb.sv
